/* rtl/mfst_pkg.sv */
`timescale 1ns / 1ps

package mfst_pkg;

    localparam int MAX_STATIONS_DEF = 64;
    localparam int MAX_PARENTS_DEF  = 16;

    localparam int ADDR_W = 48;

    localparam logic [7:0] RSSI_FLOOR_RST = 8'hAB;

    localparam logic [1:0] FTYPE_MGMT      = 2'd0;
    localparam logic [3:0] SUB_AUTH        = 4'd11;
    localparam logic [3:0] SUB_ASSOC_REQ   = 4'd0;
    localparam logic [3:0] SUB_REASSOC_REQ = 4'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_AUTH  = 2'd1;
    localparam logic [1:0] KIND_ASSOC = 2'd2;

    localparam logic CFG_OWN_BSSID  = 1'b0;
    localparam logic CFG_RSSI_FLOOR = 1'b1;

    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_NOT_KEPT   = 4'd0,
        ST_WEAK       = 4'd1,
        ST_GROUP      = 4'd2,
        ST_OWN_BSSID  = 4'd3,
        ST_UPDATED    = 4'd4,
        ST_ADDED      = 4'd5,
        ST_FULL       = 4'd6,
        ST_CLEARED    = 4'd7,
        ST_READ_OK    = 4'd8,
        ST_READ_EMPTY = 4'd9
    } t_status;

    typedef struct packed {
        logic       keep;
        t_status    status;
        logic [1:0] kind;
    } t_filt;

    typedef struct packed {
        logic              vend;
        logic [1:0]        kind;
        logic [3:0]        chan;
        logic [7:0]        rssi;
        logic [ADDR_W-1:0] parent;
        logic [ADDR_W-1:0] mac;
    } t_station;

endpackage

/* rtl/mfst_ram.sv */
`timescale 1ns / 1ps

module mfst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/mfst_filter.sv */
`timescale 1ns / 1ps

module mfst_filter (
    input  logic                        i_pkt_is_mgmt,
    input  logic [7:0]                  i_frame_ctl,
    input  logic [mfst_pkg::ADDR_W-1:0] i_source_addr,
    input  logic [mfst_pkg::ADDR_W-1:0] i_bssid_addr,
    input  logic signed [7:0]           i_rssi,
    input  logic [mfst_pkg::ADDR_W-1:0] i_own_bssid,
    input  logic signed [7:0]           i_rssi_floor,
    output mfst_pkg::t_filt             o_filt
);

    logic [1:0] ftype;
    logic [3:0] subtype;
    logic [1:0] kind;

    assign ftype   = i_frame_ctl[3:2];
    assign subtype = i_frame_ctl[7:4];

    always_comb begin
        if (subtype == mfst_pkg::SUB_AUTH) begin
            kind = mfst_pkg::KIND_AUTH;
        end else if (subtype == mfst_pkg::SUB_ASSOC_REQ ||
                     subtype == mfst_pkg::SUB_REASSOC_REQ) begin
            kind = mfst_pkg::KIND_ASSOC;
        end else begin
            kind = mfst_pkg::KIND_NONE;
        end
    end

    always_comb begin
        o_filt.kind   = kind;
        o_filt.keep   = 1'b0;
        o_filt.status = mfst_pkg::ST_NOT_KEPT;
        if (!i_pkt_is_mgmt || ftype != mfst_pkg::FTYPE_MGMT ||
            kind == mfst_pkg::KIND_NONE) begin
            o_filt.status = mfst_pkg::ST_NOT_KEPT;
        end else if (i_rssi < i_rssi_floor) begin
            o_filt.status = mfst_pkg::ST_WEAK;
        end else if (i_source_addr[0]) begin
            o_filt.status = mfst_pkg::ST_GROUP;
        end else if (i_bssid_addr == i_own_bssid) begin
            o_filt.status = mfst_pkg::ST_OWN_BSSID;
        end else begin
            o_filt.keep = 1'b1;
        end
    end

endmodule

/* rtl/mgmt_frame_station_tracker.sv */
`timescale 1ns / 1ps

// Station discovery table fed with one received frame header per transfer. Stations live in
// one single-port-read memory and BSSIDs in another, and the counts alone mark which entries
// are in use, so a clear only zeroes the counts and no clearing pass follows reset. One item is
// worked on at a time: a frame that is filtered out, a clear or a read needs no walk, while a
// kept frame walks the station memory one entry a cycle and, when it adds a station, then walks
// the parent memory. Results wait in an output register, and the next transfer is taken once
// it is loaded.
module mgmt_frame_station_tracker #(
    parameter int MAX_STATIONS = mfst_pkg::MAX_STATIONS_DEF,
    parameter int MAX_PARENTS  = mfst_pkg::MAX_PARENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [mfst_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic                        i_pkt_is_mgmt,
    input  logic [7:0]                  i_frame_ctl,
    input  logic [mfst_pkg::ADDR_W-1:0] i_source_addr,
    input  logic [mfst_pkg::ADDR_W-1:0] i_bssid_addr,
    input  logic signed [7:0]           i_rssi,
    input  logic [3:0]                  i_channel,
    input  logic                        i_vendor_match,
    input  logic [5:0]                  i_read_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [3:0]                  o_status,
    output logic [6:0]                  o_node_count,
    output logic [6:0]                  o_vendor_count,
    output logic [4:0]                  o_parent_count,
    output logic [5:0]                  o_entry_index,
    output logic [mfst_pkg::ADDR_W-1:0] o_entry_mac,
    output logic [mfst_pkg::ADDR_W-1:0] o_entry_parent,
    output logic signed [7:0]           o_entry_rssi,
    output logic [3:0]                  o_entry_channel,
    output logic [1:0]                  o_entry_kind,
    output logic                        o_entry_vendor
);

    localparam int CNT_W  = $clog2(MAX_STATIONS + 1);
    localparam int SA_W   = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int PCNT_W = $clog2(MAX_PARENTS + 1);
    localparam int PA_W   = (MAX_PARENTS > 1) ? $clog2(MAX_PARENTS) : 1;
    localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
    localparam int ST_W   = $bits(mfst_pkg::t_station);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_PSCAN,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic [mfst_pkg::ADDR_W-1:0] r_own_bssid;
    logic signed [7:0]           r_rssi_floor;
    logic [CNT_W-1:0]            r_node_cnt;
    logic [CNT_W-1:0]            r_vend_cnt;
    logic [PCNT_W-1:0]           r_par_cnt;

    logic [mfst_pkg::ADDR_W-1:0] r_src;
    logic [mfst_pkg::ADDR_W-1:0] r_bss;
    logic signed [7:0]           r_rssi;
    logic [3:0]                  r_chan;
    logic                        r_vend;
    logic [1:0]                  r_kind;

    logic [CNT_W-1:0]            r_ptr;
    logic                        r_rd_vld;
    logic [SA_W-1:0]             r_rd_idx;
    logic [PCNT_W-1:0]           r_pptr;
    logic                        r_prd_vld;

    mfst_pkg::t_status           r_res_status;
    logic                        r_res_hit;
    logic [5:0]                  r_res_idx;
    mfst_pkg::t_station          r_res_ent;

    mfst_pkg::t_filt             filt;
    logic                        in_xfer;
    logic                        out_free;

    logic                        st_we;
    logic [SA_W-1:0]             st_waddr;
    mfst_pkg::t_station          st_wdata;
    logic [SA_W-1:0]             st_raddr;
    logic [ST_W-1:0]             st_rdata_raw;
    mfst_pkg::t_station          st_rdata;
    mfst_pkg::t_station          st_upd;
    mfst_pkg::t_station          st_new;

    logic                        p_we;
    logic [PA_W-1:0]             p_waddr;
    logic [PA_W-1:0]             p_raddr;
    logic [mfst_pkg::ADDR_W-1:0] p_rdata;

    logic                        scan_hit;
    logic                        scan_issue;
    logic                        scan_miss;
    logic                        tbl_full;
    logic                        pscan_hit;
    logic                        pscan_issue;
    logic                        pscan_miss;
    logic                        read_in_range;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !o_out_valid || !i_out_stall;

    mfst_filter u_filter (
        .i_pkt_is_mgmt (i_pkt_is_mgmt),
        .i_frame_ctl   (i_frame_ctl),
        .i_source_addr (i_source_addr),
        .i_bssid_addr  (i_bssid_addr),
        .i_rssi        (i_rssi),
        .i_own_bssid   (r_own_bssid),
        .i_rssi_floor  (r_rssi_floor),
        .o_filt        (filt)
    );

    mfst_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_STATIONS),
        .AW    (SA_W)
    ) u_station_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata_raw)
    );

    mfst_ram #(
        .WIDTH (mfst_pkg::ADDR_W),
        .DEPTH (MAX_PARENTS),
        .AW    (PA_W)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (r_bss),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign st_rdata      = mfst_pkg::t_station'(st_rdata_raw);
    assign read_in_range = CMP_W'(i_read_index) < CMP_W'(r_node_cnt);

    assign scan_hit    = r_rd_vld && (st_rdata.mac == r_src);
    assign scan_issue  = r_ptr < r_node_cnt;
    assign scan_miss   = !scan_hit && !scan_issue && !r_rd_vld;
    assign tbl_full    = r_node_cnt >= CNT_W'(MAX_STATIONS);
    assign pscan_hit   = r_prd_vld && (p_rdata == r_bss);
    assign pscan_issue = r_pptr < r_par_cnt;
    assign pscan_miss  = !pscan_hit && !pscan_issue && !r_prd_vld;

    always_comb begin
        st_upd = st_rdata;
        if (r_rssi > $signed(st_rdata.rssi)) begin
            st_upd.rssi = r_rssi;
        end
        st_new.vend   = r_vend;
        st_new.kind   = r_kind;
        st_new.chan   = r_chan;
        st_new.rssi   = r_rssi;
        st_new.parent = r_bss;
        st_new.mac    = r_src;
    end

    always_comb begin
        st_raddr = r_ptr[SA_W-1:0];
        if (r_state == S_IDLE) begin
            st_raddr = SA_W'(i_read_index);
        end
        st_we    = 1'b0;
        st_waddr = r_rd_idx;
        st_wdata = st_upd;
        if (r_state == S_SCAN) begin
            if (scan_hit) begin
                st_we = 1'b1;
            end else if (scan_miss && !tbl_full) begin
                st_we    = 1'b1;
                st_waddr = r_node_cnt[SA_W-1:0];
                st_wdata = st_new;
            end
        end
        p_raddr = r_pptr[PA_W-1:0];
        p_waddr = r_par_cnt[PA_W-1:0];
        p_we    = (r_state == S_PSCAN) && pscan_miss &&
                  (r_par_cnt < PCNT_W'(MAX_PARENTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_own_bssid  <= '0;
            r_rssi_floor <= mfst_pkg::RSSI_FLOOR_RST;
            r_node_cnt   <= '0;
            r_vend_cnt   <= '0;
            r_par_cnt    <= '0;
            r_rd_vld     <= 1'b0;
            r_prd_vld    <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mfst_pkg::CFG_OWN_BSSID: begin
                        r_own_bssid <= i_cfg_data;
                    end
                    mfst_pkg::CFG_RSSI_FLOOR: begin
                        r_rssi_floor <= i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_src     <= i_source_addr;
                        r_bss     <= i_bssid_addr;
                        r_rssi    <= i_rssi;
                        r_chan    <= i_channel;
                        r_vend    <= i_vendor_match;
                        r_kind    <= filt.kind;
                        r_res_hit <= 1'b0;
                        r_rd_idx  <= SA_W'(i_read_index);
                        r_res_idx <= i_read_index;
                        r_ptr     <= '0;
                        r_rd_vld  <= 1'b0;
                        case (i_action)
                            mfst_pkg::ACT_FRAME: begin
                                r_res_status <= filt.status;
                                r_state      <= filt.keep ? S_SCAN : S_OUT;
                            end
                            mfst_pkg::ACT_CLEAR: begin
                                r_node_cnt   <= '0;
                                r_vend_cnt   <= '0;
                                r_par_cnt    <= '0;
                                r_res_status <= mfst_pkg::ST_CLEARED;
                                r_state      <= S_OUT;
                            end
                            mfst_pkg::ACT_READ: begin
                                if (read_in_range) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_res_status <= mfst_pkg::ST_READ_EMPTY;
                                    r_state      <= S_OUT;
                                end
                            end
                            default: begin
                                r_res_status <= mfst_pkg::ST_NOT_KEPT;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res_ent    <= st_rdata;
                    r_res_hit    <= 1'b1;
                    r_res_status <= mfst_pkg::ST_READ_OK;
                    r_state      <= S_OUT;
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_res_ent    <= st_upd;
                        r_res_idx    <= 6'(r_rd_idx);
                        r_res_hit    <= 1'b1;
                        r_res_status <= mfst_pkg::ST_UPDATED;
                        r_rd_vld     <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (scan_issue) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_ptr[SA_W-1:0];
                        r_ptr    <= r_ptr + 1'b1;
                    end else if (r_rd_vld) begin
                        r_rd_vld <= 1'b0;
                    end else if (tbl_full) begin
                        r_res_status <= mfst_pkg::ST_FULL;
                        r_state      <= S_OUT;
                    end else begin
                        r_res_ent    <= st_new;
                        r_res_idx    <= 6'(r_node_cnt);
                        r_res_hit    <= 1'b1;
                        r_res_status <= mfst_pkg::ST_ADDED;
                        r_node_cnt   <= r_node_cnt + 1'b1;
                        r_vend_cnt   <= r_vend_cnt + CNT_W'(r_vend);
                        r_pptr       <= '0;
                        r_prd_vld    <= 1'b0;
                        r_state      <= S_PSCAN;
                    end
                end
                S_PSCAN: begin
                    if (pscan_hit) begin
                        r_prd_vld <= 1'b0;
                        r_state   <= S_OUT;
                    end else if (pscan_issue) begin
                        r_prd_vld <= 1'b1;
                        r_pptr    <= r_pptr + 1'b1;
                    end else if (r_prd_vld) begin
                        r_prd_vld <= 1'b0;
                    end else begin
                        if (p_we) begin
                            r_par_cnt <= r_par_cnt + 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_status        <= r_res_status;
                        o_node_count    <= 7'(r_node_cnt);
                        o_vendor_count  <= 7'(r_vend_cnt);
                        o_parent_count  <= 5'(r_par_cnt);
                        o_entry_index   <= r_res_hit ? r_res_idx : 6'd0;
                        o_entry_mac     <= r_res_hit ? r_res_ent.mac : '0;
                        o_entry_parent  <= r_res_hit ? r_res_ent.parent : '0;
                        o_entry_rssi    <= r_res_hit ? r_res_ent.rssi : 8'd0;
                        o_entry_channel <= r_res_hit ? r_res_ent.chan : 4'd0;
                        o_entry_kind    <= r_res_hit ? r_res_ent.kind : 2'd0;
                        o_entry_vendor  <= r_res_hit && r_res_ent.vend;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SRC_POOL_N = 80;
    localparam int BSS_POOL_N = 24;
    localparam int PHASE_ITEMS = 232;
    localparam int TAIL_CYCLES = mfst_pkg::MAX_STATIONS_DEF + mfst_pkg::MAX_PARENTS_DEF + 10;

    typedef struct packed {
        logic [1:0]                  act;
        logic                        mgmt;
        logic [7:0]                  fc;
        logic [mfst_pkg::ADDR_W-1:0] src;
        logic [mfst_pkg::ADDR_W-1:0] bss;
        logic [7:0]                  rssi;
        logic [3:0]                  chan;
        logic                        vend;
        logic [5:0]                  ridx;
    } t_frame_item;

    typedef struct packed {
        mfst_pkg::t_status           status;
        logic [6:0]                  nodes;
        logic [6:0]                  vendors;
        logic [4:0]                  parents;
        logic [5:0]                  idx;
        logic [mfst_pkg::ADDR_W-1:0] mac;
        logic [mfst_pkg::ADDR_W-1:0] parent;
        logic [7:0]                  rssi;
        logic [3:0]                  chan;
        logic [1:0]                  kind;
        logic                        vend;
    } t_tracker_result;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic                        i_cfg_index = mfst_pkg::CFG_OWN_BSSID;
    logic [mfst_pkg::ADDR_W-1:0] i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_action = mfst_pkg::ACT_FRAME;
    logic                        i_pkt_is_mgmt = 1'b0;
    logic [7:0]                  i_frame_ctl = '0;
    logic [mfst_pkg::ADDR_W-1:0] i_source_addr = '0;
    logic [mfst_pkg::ADDR_W-1:0] i_bssid_addr = '0;
    logic signed [7:0]           i_rssi = '0;
    logic [3:0]                  i_channel = '0;
    logic                        i_vendor_match = 1'b0;
    logic [5:0]                  i_read_index = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [3:0]                  o_status;
    logic [6:0]                  o_node_count;
    logic [6:0]                  o_vendor_count;
    logic [4:0]                  o_parent_count;
    logic [5:0]                  o_entry_index;
    logic [mfst_pkg::ADDR_W-1:0] o_entry_mac;
    logic [mfst_pkg::ADDR_W-1:0] o_entry_parent;
    logic signed [7:0]           o_entry_rssi;
    logic [3:0]                  o_entry_channel;
    logic [1:0]                  o_entry_kind;
    logic                        o_entry_vendor;

    mgmt_frame_station_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_pkt_is_mgmt   (i_pkt_is_mgmt),
        .i_frame_ctl     (i_frame_ctl),
        .i_source_addr   (i_source_addr),
        .i_bssid_addr    (i_bssid_addr),
        .i_rssi          (i_rssi),
        .i_channel       (i_channel),
        .i_vendor_match  (i_vendor_match),
        .i_read_index    (i_read_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_node_count    (o_node_count),
        .o_vendor_count  (o_vendor_count),
        .o_parent_count  (o_parent_count),
        .o_entry_index   (o_entry_index),
        .o_entry_mac     (o_entry_mac),
        .o_entry_parent  (o_entry_parent),
        .o_entry_rssi    (o_entry_rssi),
        .o_entry_channel (o_entry_channel),
        .o_entry_kind    (o_entry_kind),
        .o_entry_vendor  (o_entry_vendor)
    );

    // Mirror of the station and BSSID tables and of the two registers.
    logic [mfst_pkg::ADDR_W-1:0] sta_mac    [mfst_pkg::MAX_STATIONS_DEF];
    logic [mfst_pkg::ADDR_W-1:0] sta_parent [mfst_pkg::MAX_STATIONS_DEF];
    logic signed [7:0]           sta_rssi   [mfst_pkg::MAX_STATIONS_DEF];
    logic [3:0]                  sta_chan   [mfst_pkg::MAX_STATIONS_DEF];
    logic [1:0]                  sta_kind   [mfst_pkg::MAX_STATIONS_DEF];
    logic                        sta_vend   [mfst_pkg::MAX_STATIONS_DEF];
    logic [mfst_pkg::ADDR_W-1:0] par_addr   [mfst_pkg::MAX_PARENTS_DEF];
    int                          n_sta = 0;
    int                          n_vend = 0;
    int                          n_par = 0;
    logic [mfst_pkg::ADDR_W-1:0] own_bssid_q = '0;
    logic signed [7:0]           rssi_floor_q = mfst_pkg::RSSI_FLOOR_RST;

    logic [mfst_pkg::ADDR_W-1:0] src_pool [SRC_POOL_N];
    logic [mfst_pkg::ADDR_W-1:0] bss_pool [BSS_POOL_N];

    t_frame_item       item_q [$];
    t_tracker_result   expected_q [$];
    t_frame_item       cur_item;
    bit                tb_running = 1'b0;
    bit                in_fire = 1'b0;
    bit                drain_hold = 1'b0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                fail_cnt = 0;
    int                items_taken = 0;
    int                results_checked = 0;
    int                reg_writes = 0;
    int                status_seen [16];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_tracker_result track_item(input t_frame_item it);
        t_tracker_result r;
        logic [1:0] kind;
        int hit;
        int slot;
        bit known_parent;
        r = '0;
        hit = -1;
        slot = -1;
        known_parent = 1'b0;
        kind = mfst_pkg::KIND_NONE;
        if (it.fc[7:4] == mfst_pkg::SUB_AUTH) begin
            kind = mfst_pkg::KIND_AUTH;
        end else if (it.fc[7:4] == mfst_pkg::SUB_ASSOC_REQ ||
                     it.fc[7:4] == mfst_pkg::SUB_REASSOC_REQ) begin
            kind = mfst_pkg::KIND_ASSOC;
        end
        if (it.act == mfst_pkg::ACT_FRAME) begin
            if (!it.mgmt || it.fc[3:2] != mfst_pkg::FTYPE_MGMT ||
                kind == mfst_pkg::KIND_NONE) begin
                r.status = mfst_pkg::ST_NOT_KEPT;
            end else if ($signed(it.rssi) < rssi_floor_q) begin
                r.status = mfst_pkg::ST_WEAK;
            end else if (it.src[0]) begin
                r.status = mfst_pkg::ST_GROUP;
            end else if (it.bss == own_bssid_q) begin
                r.status = mfst_pkg::ST_OWN_BSSID;
            end else begin
                for (int i = 0; i < n_sta; i++) begin
                    if (hit < 0 && sta_mac[i] == it.src) hit = i;
                end
                if (hit >= 0) begin
                    if ($signed(it.rssi) > sta_rssi[hit]) sta_rssi[hit] = it.rssi;
                    slot = hit;
                    r.status = mfst_pkg::ST_UPDATED;
                end else if (n_sta >= mfst_pkg::MAX_STATIONS_DEF) begin
                    r.status = mfst_pkg::ST_FULL;
                end else begin
                    slot = n_sta;
                    sta_mac[slot] = it.src;
                    sta_parent[slot] = it.bss;
                    sta_rssi[slot] = it.rssi;
                    sta_chan[slot] = it.chan;
                    sta_kind[slot] = kind;
                    sta_vend[slot] = it.vend;
                    n_sta++;
                    if (it.vend) n_vend++;
                    for (int i = 0; i < n_par; i++) begin
                        if (par_addr[i] == it.bss) known_parent = 1'b1;
                    end
                    if (!known_parent && n_par < mfst_pkg::MAX_PARENTS_DEF) begin
                        par_addr[n_par] = it.bss;
                        n_par++;
                    end
                    r.status = mfst_pkg::ST_ADDED;
                end
            end
        end else if (it.act == mfst_pkg::ACT_CLEAR) begin
            n_sta = 0;
            n_vend = 0;
            n_par = 0;
            r.status = mfst_pkg::ST_CLEARED;
        end else if (it.act == mfst_pkg::ACT_READ) begin
            if (int'(it.ridx) < n_sta) begin
                slot = int'(it.ridx);
                r.status = mfst_pkg::ST_READ_OK;
            end else begin
                r.status = mfst_pkg::ST_READ_EMPTY;
            end
        end else begin
            r.status = mfst_pkg::ST_NOT_KEPT;
        end
        if (slot >= 0) begin
            r.idx = 6'(slot);
            r.mac = sta_mac[slot];
            r.parent = sta_parent[slot];
            r.rssi = sta_rssi[slot];
            r.chan = sta_chan[slot];
            r.kind = sta_kind[slot];
            r.vend = sta_vend[slot];
        end
        r.nodes = 7'(n_sta);
        r.vendors = 7'(n_vend);
        r.parents = 5'(n_par);
        return r;
    endfunction

    function automatic t_frame_item frame_item(input logic [7:0] fc,
                                               input logic [mfst_pkg::ADDR_W-1:0] src,
                                               input logic [mfst_pkg::ADDR_W-1:0] bss,
                                               input logic [7:0] rssi,
                                               input logic [3:0] chan,
                                               input logic vend);
        t_frame_item it;
        it.act = mfst_pkg::ACT_FRAME;
        it.mgmt = 1'b1;
        it.fc = fc;
        it.src = src;
        it.bss = bss;
        it.rssi = rssi;
        it.chan = chan;
        it.vend = vend;
        it.ridx = 6'($urandom);
        return it;
    endfunction

    function automatic t_frame_item ctl_item(input logic [1:0] act, input logic [5:0] ridx);
        t_frame_item it;
        it = frame_item(8'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        8'($urandom), 4'($urandom_range(14)), 1'($urandom));
        it.mgmt = 1'($urandom);
        it.act = act;
        it.ridx = ridx;
        return it;
    endfunction

    // Mostly well-formed frames drawn from small address pools, so that sources repeat and
    // both tables fill up, with filtered frames, reads and the odd clear mixed in.
    function automatic t_frame_item random_item();
        t_frame_item it;
        int pick;
        int lo;
        logic [3:0] sub;
        pick = $urandom_range(99);
        lo = int'(rssi_floor_q);
        case ($urandom_range(2))
            0: sub = mfst_pkg::SUB_AUTH;
            1: sub = mfst_pkg::SUB_ASSOC_REQ;
            default: sub = mfst_pkg::SUB_REASSOC_REQ;
        endcase
        it = frame_item({sub, mfst_pkg::FTYPE_MGMT, 2'($urandom)},
                        src_pool[$urandom_range(SRC_POOL_N - 1)],
                        bss_pool[$urandom_range(BSS_POOL_N - 1)],
                        8'(lo + int'($urandom_range(127 - lo))),
                        4'($urandom_range(14)), 1'($urandom));
        if (pick < 4) begin
            it.fc = 8'($urandom);
        end else if (pick < 7) begin
            it.mgmt = 1'b0;
        end else if (pick < 11) begin
            it.rssi = 8'($urandom);
        end else if (pick < 14) begin
            it.src[0] = 1'b1;
        end else if (pick < 17) begin
            it.bss = own_bssid_q;
        end else if (pick < 19) begin
            it.src = 48'({$urandom, $urandom});
        end else if (pick < 27) begin
            it = ctl_item(mfst_pkg::ACT_READ, 6'($urandom));
        end else if (pick < 28) begin
            it = ctl_item(ACT_UNUSED, 6'($urandom));
        end else if (pick == 28 && $urandom_range(2) == 0) begin
            it = ctl_item(mfst_pkg::ACT_CLEAR, 6'($urandom));
        end
        return it;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [mfst_pkg::ADDR_W-1:0] want,
                                        input logic [mfst_pkg::ADDR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic write_reg(input logic idx, input logic [mfst_pkg::ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == mfst_pkg::CFG_OWN_BSSID) begin
            own_bssid_q = data;
        end else begin
            rssi_floor_q = data[7:0];
        end
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || i_in_valid || expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Driver: offers the next pending frame once the previous transfer has gone through.
    always @(negedge i_clk) begin
        if (!tb_running) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (drain_hold && expected_q.size() == 0 && !i_in_valid) begin
                drain_hold = 1'b0;
            end else if (!drain_hold && $urandom_range(199) == 0) begin
                drain_hold = 1'b1;
            end
            if (!i_in_valid || in_fire) begin
                if (item_q.size() != 0 && !drain_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_item = item_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_action <= cur_item.act;
                    i_pkt_is_mgmt <= cur_item.mgmt;
                    i_frame_ctl <= cur_item.fc;
                    i_source_addr <= cur_item.src;
                    i_bssid_addr <= cur_item.bss;
                    i_rssi <= cur_item.rssi;
                    i_channel <= cur_item.chan;
                    i_vendor_match <= cur_item.vend;
                    i_read_index <= cur_item.ridx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        t_tracker_result got;
        t_tracker_result want;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_q.push_back(track_item(cur_item));
            items_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = mfst_pkg::t_status'(o_status);
            got.nodes = o_node_count;
            got.vendors = o_vendor_count;
            got.parents = o_parent_count;
            got.idx = o_entry_index;
            got.mac = o_entry_mac;
            got.parent = o_entry_parent;
            got.rssi = o_entry_rssi;
            got.chan = o_entry_channel;
            got.kind = o_entry_kind;
            got.vend = o_entry_vendor;
            if (expected_q.size() == 0) begin
                $error("result transfer with status %0d arrived with nothing expected",
                       o_status);
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                check_field("status", 48'(want.status), 48'(got.status));
                check_field("node_count", 48'(want.nodes), 48'(got.nodes));
                check_field("vendor_count", 48'(want.vendors), 48'(got.vendors));
                check_field("parent_count", 48'(want.parents), 48'(got.parents));
                check_field("entry_index", 48'(want.idx), 48'(got.idx));
                check_field("entry_mac", want.mac, got.mac);
                check_field("entry_parent", want.parent, got.parent);
                check_field("entry_rssi", 48'(want.rssi), 48'(got.rssi));
                check_field("entry_channel", 48'(want.chan), 48'(got.chan));
                check_field("entry_kind", 48'(want.kind), 48'(got.kind));
                check_field("entry_vendor", 48'(want.vend), 48'(got.vend));
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    initial begin
        logic [mfst_pkg::ADDR_W-1:0] src_a;
        logic [mfst_pkg::ADDR_W-1:0] src_c;
        logic [mfst_pkg::ADDR_W-1:0] src_d;
        logic [mfst_pkg::ADDR_W-1:0] bss_b;
        logic [mfst_pkg::ADDR_W-1:0] bss_e;
        logic [7:0] fc_auth;
        logic [7:0] fc_assoc;
        logic [7:0] fc_reassoc;
        t_frame_item it;

        for (int i = 0; i < 16; i++) status_seen[i] = 0;
        src_a = 48'h6655_4433_2210;
        src_c = 48'h0000_0000_0002;
        src_d = 48'hFEDC_BA98_7654;
        bss_b = 48'h1234_5678_9ABC;
        bss_e = 48'hFFFF_FFFF_FFFF;
        fc_auth = {mfst_pkg::SUB_AUTH, mfst_pkg::FTYPE_MGMT, 2'b00};
        fc_assoc = {mfst_pkg::SUB_ASSOC_REQ, mfst_pkg::FTYPE_MGMT, 2'b00};
        fc_reassoc = {mfst_pkg::SUB_REASSOC_REQ, mfst_pkg::FTYPE_MGMT, 2'b11};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        tb_running = 1'b1;

        // Directed part with the registers at their reset values.
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd0));
        item_q.push_back(frame_item(fc_auth, src_a, bss_b, 8'sd0, 4'd3, 1'b0));
        item_q.push_back(frame_item(fc_auth, src_a, bss_b, -8'sd10, 4'd3, 1'b0));
        item_q.push_back(frame_item(fc_assoc, src_a, bss_e, 8'sd0, 4'd5, 1'b1));
        item_q.push_back(frame_item(fc_auth, src_a, bss_b, 8'sd127, 4'd3, 1'b0));
        item_q.push_back(frame_item(fc_assoc, src_c, bss_b, mfst_pkg::RSSI_FLOOR_RST, 4'd14,
                                    1'b1));
        item_q.push_back(frame_item(fc_reassoc, src_d, bss_e, -8'sd40, 4'd0, 1'b0));
        item_q.push_back(frame_item(fc_auth, 48'h0000_0000_0100, bss_b, -8'sd86, 4'd1, 1'b0));
        item_q.push_back(frame_item(fc_auth, 48'h0000_0000_0200, bss_b, -8'sd128, 4'd1, 1'b0));
        item_q.push_back(frame_item(fc_auth, 48'h0000_0000_0301, bss_b, 8'sd10, 4'd1, 1'b0));
        item_q.push_back(frame_item(fc_auth, 48'h0000_0000_0400, 48'd0, 8'sd10, 4'd1, 1'b0));
        it = frame_item(fc_auth, 48'h0000_0000_0500, bss_b, 8'sd10, 4'd1, 1'b0);
        it.mgmt = 1'b0;
        item_q.push_back(it);
        item_q.push_back(frame_item(8'hB4, 48'h0000_0000_0600, bss_b, 8'sd10, 4'd1, 1'b0));
        item_q.push_back(frame_item(8'h40, 48'h0000_0000_0700, bss_b, 8'sd10, 4'd1, 1'b0));
        item_q.push_back(frame_item(8'hFF, 48'h0000_0000_0800, bss_b, 8'sd10, 4'd1, 1'b0));
        item_q.push_back(ctl_item(ACT_UNUSED, 6'd1));
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd0));
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd2));
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd3));
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd63));
        item_q.push_back(ctl_item(mfst_pkg::ACT_CLEAR, 6'd0));
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd0));
        item_q.push_back(frame_item(fc_auth, 48'hFFFF_FFFF_FFFE, bss_e, 8'sd127, 4'd14, 1'b1));
        item_q.push_back(ctl_item(mfst_pkg::ACT_READ, 6'd0));
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < SRC_POOL_N; i++) begin
                src_pool[i] = 48'({$urandom, $urandom}) & ~48'd1;
            end
            for (int i = 0; i < BSS_POOL_N; i++) bss_pool[i] = 48'({$urandom, $urandom});
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_reg(mfst_pkg::CFG_OWN_BSSID, '1);
                    write_reg(mfst_pkg::CFG_RSSI_FLOOR, 48'(8'h80));
                end
                1: begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                    write_reg(mfst_pkg::CFG_OWN_BSSID, bss_pool[0]);
                    write_reg(mfst_pkg::CFG_RSSI_FLOOR, 48'(mfst_pkg::RSSI_FLOOR_RST));
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                    write_reg(mfst_pkg::CFG_OWN_BSSID, '0);
                    write_reg(mfst_pkg::CFG_RSSI_FLOOR, 48'(8'h7F));
                end
                default: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                    write_reg(mfst_pkg::CFG_OWN_BSSID, 48'({$urandom, $urandom}));
                    write_reg(mfst_pkg::CFG_RSSI_FLOOR, 48'({$urandom, $urandom}));
                end
            endcase
            item_q.push_back(ctl_item(mfst_pkg::ACT_CLEAR, 6'($urandom)));
            for (int i = 1; i < PHASE_ITEMS; i++) item_q.push_back(random_item());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d input transfers and %0d checked results over %0d register writes.",
                 items_taken, results_checked, reg_writes);
        $display("Added %0d, updated %0d, refused when full %0d, read %0d, cleared %0d.",
                 status_seen[mfst_pkg::ST_ADDED], status_seen[mfst_pkg::ST_UPDATED],
                 status_seen[mfst_pkg::ST_FULL], status_seen[mfst_pkg::ST_READ_OK],
                 status_seen[mfst_pkg::ST_CLEARED]);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mfst_pkg.sv
rtl/mfst_ram.sv
rtl/mfst_filter.sv
rtl/mgmt_frame_station_tracker.sv
tb/sv/tb_top.sv
